>>> sv/tmq_pkg.sv
package tmq_pkg;

	localparam int TIME_W     = 64;
	localparam int DATA_W     = 32;
	localparam int SRC_W      = 2;
	localparam int NUM_QUEUES = 3;

	// queue codes
	localparam logic [SRC_W-1:0] SRC_CAMERA = 2'd0;
	localparam logic [SRC_W-1:0] SRC_ACCEL  = 2'd1;
	localparam logic [SRC_W-1:0] SRC_GYRO   = 2'd2;

	// operation codes
	localparam logic OP_PUSH     = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	// front timestamp of an empty queue
	localparam logic [TIME_W-1:0] TIME_EMPTY = {TIME_W{1'b1}};

	typedef struct packed {
		logic load;
		logic do_push;
		logic do_pick;
	} tmq_cmd_t;

	typedef struct packed {
		logic in_dispatch;
	} tmq_sts_t;

endpackage

>>> sv/tmq_if.sv
interface tmq_in_if;
	import tmq_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [SRC_W-1:0]  sample_source;
	logic [TIME_W-1:0] sample_time;
	logic [DATA_W-1:0] sample_data;

	modport source (output valid, output op, output sample_source, output sample_time,
		output sample_data, input ready);
	modport sink (input valid, input op, input sample_source, input sample_time,
		input sample_data, output ready);
endinterface

interface tmq_out_if;
	import tmq_pkg::*;

	logic              valid;
	logic              ready;
	logic              push_accepted;
	logic              out_valid;
	logic [SRC_W-1:0]  out_source;
	logic [TIME_W-1:0] out_time;
	logic [DATA_W-1:0] out_data;

	modport source (output valid, output push_accepted, output out_valid,
		output out_source, output out_time, output out_data, input ready);
	modport sink (input valid, input push_accepted, input out_valid,
		input out_source, input out_time, input out_data, output ready);
endinterface

>>> sv/timestamp_merge_three_ring_queues.sv
// timestamp-ordered merge of three overwriting sensor ring queues
//
// sample_ch takes one item per handshake: op 0 pushes sample_time and
// sample_data into the queue named by sample_source (camera, accel, gyro),
// op 1 dispatches the queued sample with the smallest timestamp (ties go to
// camera, then accel, then gyro). every item gives exactly one result item
// on result_ch. a push to a full queue overwrites its oldest sample.
// enable_we / enable_wdata write the enable bit; pushes are refused while
// it is low, dispatch still drains.
//
// a push passes through the push state, which updates the ring; a dispatch
// passes through a read state (head read from the ring memories), then a
// pick state (three-way compare and pop). one item is in flight at a time;
// the next item is taken in the cycle its predecessor's result leaves.
// a stalled receiver holds the result and blocks new items until taken.
// reset empties all queues and clears enable; ring contents are not cleared
module timestamp_merge_three_ring_queues #(
	parameter int QUEUE_DEPTH  = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      enable_we,
	input  logic      enable_wdata,
	tmq_in_if.sink    sample_ch,
	tmq_out_if.source result_ch
);
	import tmq_pkg::*;

	tmq_cmd_t cmd;
	tmq_sts_t sts;

	// sequencer: idle, push or read/pick, then hold the result
	tmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// rings, pointers, head compare and result register
	tmq_datapath #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable_we     (enable_we),
		.enable_wdata  (enable_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.op            (sample_ch.op),
		.source        (sample_ch.sample_source),
		.sample_time   (sample_ch.sample_time),
		.sample_data   (sample_ch.sample_data),
		.push_accepted (result_ch.push_accepted),
		.out_valid     (result_ch.out_valid),
		.out_source    (result_ch.out_source),
		.out_time      (result_ch.out_time),
		.out_data      (result_ch.out_data)
	);
endmodule

>>> sv/tmq_ctrl.sv
module tmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tmq_pkg::tmq_sts_t sts,
	output tmq_pkg::tmq_cmd_t cmd
);
	import tmq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_READ,
		S_PICK,
		S_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	// a new item may enter as the previous result leaves
	assign in_ready  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);

	assign cmd.load    = accept;
	assign cmd.do_push = (state_q == S_PUSH);
	assign cmd.do_pick = (state_q == S_PICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (accept) begin
						state_q <= sts.in_dispatch ? S_READ : S_PUSH;
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_PUSH: state_q <= S_OUT;
				S_READ: state_q <= S_PICK;
				S_PICK: state_q <= S_OUT;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/tmq_datapath.sv
module tmq_datapath #(
	parameter int QUEUE_DEPTH  = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable_we,
	input  logic                       enable_wdata,
	input  tmq_pkg::tmq_cmd_t          cmd,
	output tmq_pkg::tmq_sts_t          sts,
	input  logic                       op,
	input  logic [tmq_pkg::SRC_W-1:0]  source,
	input  logic [tmq_pkg::TIME_W-1:0] sample_time,
	input  logic [tmq_pkg::DATA_W-1:0] sample_data,
	output logic                       push_accepted,
	output logic                       out_valid,
	output logic [tmq_pkg::SRC_W-1:0]  out_source,
	output logic [tmq_pkg::TIME_W-1:0] out_time,
	output logic [tmq_pkg::DATA_W-1:0] out_data
);
	import tmq_pkg::*;

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

	// sample storage, one ring per queue
	logic [TIME_W-1:0]       time_mem [NUM_QUEUES][QUEUE_DEPTH];
	logic [PAYLOAD_BITS-1:0] data_mem [NUM_QUEUES][QUEUE_DEPTH];

	logic [IDX_W-1:0]  rd_idx_q [NUM_QUEUES];
	logic [IDX_W-1:0]  wr_idx_q [NUM_QUEUES];
	logic [FILL_W-1:0] fill_q   [NUM_QUEUES];

	logic [TIME_W-1:0]       head_time_q [NUM_QUEUES];
	logic [PAYLOAD_BITS-1:0] head_data_q [NUM_QUEUES];

	logic                    enable_q;
	logic [SRC_W-1:0]        source_q;
	logic [TIME_W-1:0]       time_q;
	logic [PAYLOAD_BITS-1:0] data_q;

	logic [63:0]       data_wide;
	logic              push_ok;
	logic              found;
	logic [SRC_W-1:0]  best;
	logic [TIME_W-1:0] best_time;
	logic [63:0]       head_wide;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
	endfunction

	assign sts.in_dispatch = (op == OP_DISPATCH);
	assign data_wide       = 64'(sample_data);
	assign push_ok         = enable_q && (source_q == SRC_CAMERA || source_q == SRC_ACCEL
		|| source_q == SRC_GYRO);

	// earliest head, ties to the lower queue number
	always_comb begin
		found     = 1'b0;
		best      = SRC_CAMERA;
		best_time = TIME_EMPTY;
		for (int q = 0; q < NUM_QUEUES; q++) begin
			if (fill_q[q] != '0 && (!found || head_time_q[q] < best_time)) begin
				found     = 1'b1;
				best      = SRC_W'(q);
				best_time = head_time_q[q];
			end
		end
	end

	assign head_wide = 64'(head_data_q[best]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (enable_we) begin
			enable_q <= enable_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			source_q <= source;
			time_q   <= sample_time;
			data_q   <= data_wide[PAYLOAD_BITS-1:0];
		end
	end

	// memory write and registered head read
	always_ff @(posedge clk) begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			if (cmd.do_push && push_ok && source_q == SRC_W'(q)) begin
				time_mem[q][wr_idx_q[q]] <= time_q;
				data_mem[q][wr_idx_q[q]] <= data_q;
			end
			head_time_q[q] <= time_mem[q][rd_idx_q[q]];
			head_data_q[q] <= data_mem[q][rd_idx_q[q]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				rd_idx_q[q] <= '0;
				wr_idx_q[q] <= '0;
				fill_q[q]   <= '0;
			end
		end else begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				if (cmd.do_push && push_ok && source_q == SRC_W'(q)) begin
					wr_idx_q[q] <= next_slot(wr_idx_q[q]);
					if (fill_q[q] == FILL_FULL) begin
						rd_idx_q[q] <= next_slot(rd_idx_q[q]);
					end else begin
						fill_q[q] <= fill_q[q] + FILL_W'(1);
					end
				end else if (cmd.do_pick && found && best == SRC_W'(q)) begin
					rd_idx_q[q] <= next_slot(rd_idx_q[q]);
					fill_q[q]   <= fill_q[q] - FILL_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			push_accepted <= push_ok;
			out_valid     <= 1'b0;
			out_source    <= '0;
			out_time      <= '0;
			out_data      <= '0;
		end else if (cmd.do_pick) begin
			push_accepted <= 1'b0;
			out_valid     <= found;
			out_source    <= found ? best : '0;
			out_time      <= found ? best_time : '0;
			out_data      <= found ? head_wide[DATA_W-1:0] : '0;
		end
	end
endmodule
